// File: design/vbb_pkg.sv
// ---------------------------------------------------------------------------
// vbb_pkg
// Shared constants, codes and types of the voxel box bitmap unit.
// ---------------------------------------------------------------------------
`default_nettype none

package vbb_pkg;

    localparam int MAX_EDGE = 32;
    localparam int CW       = 26;
    localparam int EW       = $clog2(MAX_EDGE + 1);
    localparam int DCW      = $clog2(EW);
    localparam int VOXELS   = MAX_EDGE * MAX_EDGE * MAX_EDGE;
    localparam int IW       = $clog2(VOXELS);
    localparam int SW       = CW + 3;
    localparam int CNT_W    = 16;
    localparam int FUNC_W   = 3;
    localparam int STAT_W   = 2;

    typedef logic signed [CW-1:0] coord_t;

    typedef enum logic [FUNC_W-1:0] {
        FN_SET      = 3'd0,
        FN_QUERY    = 3'd1,
        FN_EMPTY    = 3'd2,
        FN_SHIFT    = 3'd3,
        FN_RESAMPLE = 3'd4
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_OUTSIDE = 2'd2
    } status_t;

endpackage

`default_nettype wire

// File: design/vbb_if.sv
// ---------------------------------------------------------------------------
// vbb_in_if / vbb_out_if
// Valid/ready channels of the voxel box bitmap unit.
// ---------------------------------------------------------------------------
`default_nettype none

interface vbb_in_if import vbb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    coord_t            px;
    coord_t            py;
    coord_t            pz;
    coord_t            qx;
    coord_t            qy;
    coord_t            qz;
    logic              include_req;

    modport source (output valid, func, px, py, pz, qx, qy, qz, include_req, input ready);
    modport sink   (input valid, func, px, py, pz, qx, qy, qz, include_req, output ready);
endinterface

interface vbb_out_if import vbb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              hit;
    logic [CNT_W-1:0]  count;
    logic [STAT_W-1:0] status;

    modport source (output valid, hit, count, status, input ready);
    modport sink   (input valid, hit, count, status, output ready);
endinterface

`default_nettype wire

// File: design/vbb_ram.sv
// ---------------------------------------------------------------------------
// vbb_ram
// Generic RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module vbb_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: design/voxel_box_bitmap_unit.sv
// ---------------------------------------------------------------------------
// voxel_box_bitmap_unit
// 3D occupancy bitmap over a box, held in two 1-bit banks, with a count.
// ---------------------------------------------------------------------------
//  channel  | dir | fields
//  in_ch    | in  | func, px, py, pz, qx, qy, qz, include_req
//  out_ch   | out | hit, count, status
//
//  Set and query pass through locate, multiply and read, modify-write and
//  output; a new item is taken only once the last is handed to the output.
//  Re-box: resampling first runs a division; then, for each voxel of the new
//  box, one read of the old bank and one write of the new.
//  After reset a clearing pass zeroes entry 0 of bank A.
//  A result waits in the output register; the next item is accepted then.
// ---------------------------------------------------------------------------
`default_nettype none

module voxel_box_bitmap_unit import vbb_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    vbb_in_if.sink    in_ch,
    vbb_out_if.source out_ch
);

    typedef enum logic [10:0] {
        S_INIT  = 11'b000_0000_0001,
        S_IDLE  = 11'b000_0000_0010,
        S_LOC   = 11'b000_0000_0100,
        S_ADDR  = 11'b000_0000_1000,
        S_RMW   = 11'b000_0001_0000,
        S_SETUP = 11'b000_0010_0000,
        S_DIV   = 11'b000_0100_0000,
        S_WA    = 11'b000_1000_0000,
        S_WB    = 11'b001_0000_0000,
        S_WC    = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } state_t;

    typedef struct packed {
        logic [EW-1:0] n;
        logic [SW-1:0] s;
        logic [EW-1:0] r;
    } axis_t;

    function automatic axis_t axis_adv(axis_t a, logic [EW-1:0] q, logic [EW-1:0] rs,
                                       logic [EW-1:0] ned);
        axis_t       o;
        logic [EW:0] rsum;
        rsum = {1'b0, a.r} + {1'b0, rs};
        o.n  = a.n + EW'(1);
        if (rsum >= {1'b0, ned})
        begin
            o.r = EW'(rsum - {1'b0, ned});
            o.s = a.s + SW'(q) + SW'(1);
        end
        else
        begin
            o.r = EW'(rsum);
            o.s = a.s + SW'(q);
        end
        return o;
    endfunction

    state_t            state_reg, state_next;
    logic [FUNC_W-1:0] func_reg, func_next;
    coord_t            p_reg [3], p_next [3];
    coord_t            q_reg [3], q_next [3];
    logic              inc_reg, inc_next;
    coord_t            c1_reg [3], c1_next [3];
    coord_t            mn_reg [3], mn_next [3];
    logic [EW-1:0]     edge_reg [3], edge_next [3];
    logic              active_reg, active_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    coord_t            nmn_reg [3], nmn_next [3];
    logic [EW-1:0]     ned_reg [3], ned_next [3];
    logic [SW-1:0]     sinit_reg [3], sinit_next [3];
    logic [EW-1:0]     qst_reg [3], qst_next [3];
    logic [EW-1:0]     rstep_reg [3], rstep_next [3];
    axis_t             ax_reg [3], ax_next [3];
    logic [EW-1:0]     quo_reg [3], quo_next [3];
    logic [EW:0]       rem_reg [3], rem_next [3];
    logic [DCW-1:0]    dcnt_reg, dcnt_next;
    logic [IW-1:0]     di_reg, di_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IW-1:0]     t_reg, t_next;
    logic [IW-1:0]     addr_reg, addr_next;
    logic              inside_reg, inside_next;
    logic              hit_reg, hit_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_hit_reg, out_hit_next;
    logic [CNT_W-1:0]  out_count_reg, out_count_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;

    logic [CW:0]       lx [3];
    logic              loc_in;
    logic [IW-1:0]     loc_t;
    logic [CW:0]       g_diff [3];
    logic [CW:0]       g_edge [3];
    coord_t            g_mn [3];
    coord_t            g_hi [3];
    logic              too_big;
    logic              w_in;
    logic [IW-1:0]     w_t;
    logic [EW:0]       dtmp [3];
    logic              dge [3];
    logic              bitv;
    axis_t             adv [3];
    axis_t             rst_ax [3];
    logic              end_x, end_z, end_y;

    logic              ram_we_a, ram_we_b;
    logic              wr_en, wr_bank, wr_data;
    logic [IW-1:0]     wr_addr, rd_addr;
    logic              rdata_a, rdata_b, cur_rdata;

    vbb_ram #(.WIDTH(1), .DEPTH(VOXELS)) u_bank_a (
        .clk   (clk),
        .we    (ram_we_a),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rdata_a)
    );

    vbb_ram #(.WIDTH(1), .DEPTH(VOXELS)) u_bank_b (
        .clk   (clk),
        .we    (ram_we_b),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rdata_b)
    );

    assign ram_we_a  = wr_en && !wr_bank;
    assign ram_we_b  = wr_en && wr_bank;
    assign cur_rdata = active_reg ? rdata_b : rdata_a;

    assign in_ch.ready   = (state_reg == S_IDLE);
    assign out_ch.valid  = out_valid_reg;
    assign out_ch.hit    = out_hit_reg;
    assign out_ch.count  = out_count_reg;
    assign out_ch.status = out_status_reg;

    always_comb
    begin
        loc_in  = 1'b1;
        too_big = 1'b0;
        w_in    = (func_reg != FN_EMPTY);
        for (int k = 0; k < 3; k++)
        begin
            lx[k]  = {p_reg[k][CW-1], p_reg[k]} - {mn_reg[k][CW-1], mn_reg[k]};
            loc_in = loc_in && !lx[k][CW] && (lx[k][CW-1:0] < CW'(edge_reg[k]));

            g_mn[k]   = (p_reg[k] < q_reg[k]) ? p_reg[k] : q_reg[k];
            g_hi[k]   = (p_reg[k] < q_reg[k]) ? q_reg[k] : p_reg[k];
            g_diff[k] = {g_hi[k][CW-1], g_hi[k]} - {g_mn[k][CW-1], g_mn[k]};
            g_edge[k] = g_diff[k] + (CW+1)'(1);
            too_big   = too_big || (g_edge[k] > (CW+1)'(MAX_EDGE));

            w_in = w_in && !ax_reg[k].s[SW-1]
                 && (ax_reg[k].s[SW-2:0] < (SW-1)'(edge_reg[k]));

            dtmp[k] = {rem_reg[k][EW-1:0], quo_reg[k][EW-1]};
            dge[k]  = (dtmp[k] >= {1'b0, ned_reg[k]});

            adv[k]    = axis_adv(ax_reg[k], qst_reg[k], rstep_reg[k], ned_reg[k]);
            rst_ax[k] = '{n: '0, s: sinit_reg[k], r: '0};
        end
        loc_t = IW'(lx[1][EW-1:0]) * IW'(edge_reg[2]) + IW'(lx[2][EW-1:0]);
        w_t   = IW'(ax_reg[1].s[EW-1:0]) * IW'(edge_reg[2]) + IW'(ax_reg[2].s[EW-1:0]);
        end_x = (ax_reg[0].n == ned_reg[0] - EW'(1));
        end_z = (ax_reg[2].n == ned_reg[2] - EW'(1));
        end_y = (ax_reg[1].n == ned_reg[1] - EW'(1));
        bitv  = inside_reg && cur_rdata;
    end

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        inc_next        = inc_reg;
        active_next     = active_reg;
        count_next      = count_reg;
        dcnt_next       = dcnt_reg;
        di_next         = di_reg;
        cnt_next        = cnt_reg;
        t_next          = t_reg;
        addr_next       = addr_reg;
        inside_next     = inside_reg;
        hit_next        = hit_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        out_hit_next    = out_hit_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        p_next          = p_reg;
        q_next          = q_reg;
        c1_next         = c1_reg;
        mn_next         = mn_reg;
        edge_next       = edge_reg;
        nmn_next        = nmn_reg;
        ned_next        = ned_reg;
        sinit_next      = sinit_reg;
        qst_next        = qst_reg;
        rstep_next      = rstep_reg;
        ax_next         = ax_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        wr_en           = 1'b0;
        wr_bank         = active_reg;
        wr_addr         = addr_reg;
        wr_data         = 1'b0;
        rd_addr         = addr_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                wr_en      = 1'b1;
                wr_bank    = 1'b0;
                wr_addr    = '0;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    func_next   = in_ch.func;
                    p_next[0]   = in_ch.px;
                    p_next[1]   = in_ch.py;
                    p_next[2]   = in_ch.pz;
                    q_next[0]   = in_ch.qx;
                    q_next[1]   = in_ch.qy;
                    q_next[2]   = in_ch.qz;
                    inc_next    = in_ch.include_req;
                    hit_next    = 1'b0;
                    status_next = ST_OK;
                    case (in_ch.func)
                        FN_SET, FN_QUERY:                state_next = S_LOC;
                        FN_EMPTY, FN_SHIFT, FN_RESAMPLE: state_next = S_SETUP;
                        default:                         state_next = S_DONE;
                    endcase
                end
            end
            S_LOC:
            begin
                inside_next = loc_in;
                t_next      = loc_t;
                state_next  = S_ADDR;
            end
            S_ADDR:
            begin
                rd_addr    = IW'(t_reg * IW'(edge_reg[0])) + IW'(lx[0][EW-1:0]);
                addr_next  = rd_addr;
                state_next = S_RMW;
            end
            S_RMW:
            begin
                if (!inside_reg)
                begin
                    status_next = ST_OUTSIDE;
                end
                else if (func_reg == FN_QUERY)
                begin
                    hit_next = cur_rdata;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_data = inc_reg;
                    if (cur_rdata && !inc_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    else if (!cur_rdata && inc_reg)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                state_next = S_DONE;
            end
            S_SETUP:
            begin
                if (too_big)
                begin
                    status_next = ST_REFUSED;
                    state_next  = S_DONE;
                end
                else
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        nmn_next[k]   = g_mn[k];
                        ned_next[k]   = EW'(g_edge[k]);
                        sinit_next[k] = (func_reg == FN_SHIFT)
                                      ? SW'(g_mn[k]) - SW'(p_reg[k])
                                        + SW'(c1_reg[k]) - SW'(mn_reg[k])
                                      : '0;
                        ax_next[k]    = '{n: '0, s: sinit_next[k], r: '0};
                        qst_next[k]   = EW'(1);
                        rstep_next[k] = '0;
                        quo_next[k]   = edge_reg[k];
                        rem_next[k]   = '0;
                    end
                    di_next    = '0;
                    cnt_next   = '0;
                    dcnt_next  = '0;
                    state_next = (func_reg == FN_RESAMPLE) ? S_DIV : S_WA;
                end
            end
            S_DIV:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    rem_next[k] = dge[k] ? dtmp[k] - {1'b0, ned_reg[k]} : dtmp[k];
                    quo_next[k] = {quo_reg[k][EW-2:0], dge[k]};
                    qst_next[k]   = quo_next[k];
                    rstep_next[k] = rem_next[k][EW-1:0];
                end
                dcnt_next = dcnt_reg + DCW'(1);
                if (dcnt_reg == DCW'(EW - 1))
                begin
                    state_next = S_WA;
                end
            end
            S_WA:
            begin
                inside_next = w_in;
                t_next      = w_t;
                state_next  = S_WB;
            end
            S_WB:
            begin
                rd_addr    = IW'(t_reg * IW'(edge_reg[0])) + IW'(ax_reg[0].s[EW-1:0]);
                state_next = S_WC;
            end
            S_WC:
            begin
                wr_en    = 1'b1;
                wr_bank  = !active_reg;
                wr_addr  = di_reg;
                wr_data  = bitv;
                cnt_next = cnt_reg + CNT_W'(bitv);
                di_next  = di_reg + IW'(1);
                if (!end_x)
                begin
                    ax_next[0] = adv[0];
                end
                else
                begin
                    ax_next[0] = rst_ax[0];
                    if (!end_z)
                    begin
                        ax_next[2] = adv[2];
                    end
                    else
                    begin
                        ax_next[2] = rst_ax[2];
                        ax_next[1] = adv[1];
                    end
                end
                if (end_x && end_z && end_y)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        c1_next[k]   = p_reg[k];
                        mn_next[k]   = nmn_reg[k];
                        edge_next[k] = ned_reg[k];
                    end
                    active_next = !active_reg;
                    count_next  = cnt_next;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_WA;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_hit_next    = hit_reg;
                    out_count_next  = count_reg;
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
            count_reg     <= '0;
            for (int k = 0; k < 3; k++)
            begin
                c1_reg[k]   <= '0;
                mn_reg[k]   <= '0;
                edge_reg[k] <= EW'(1);
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            active_reg    <= active_next;
            count_reg     <= count_next;
            c1_reg        <= c1_next;
            mn_reg        <= mn_next;
            edge_reg      <= edge_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        p_reg          <= p_next;
        q_reg          <= q_next;
        inc_reg        <= inc_next;
        nmn_reg        <= nmn_next;
        ned_reg        <= ned_next;
        sinit_reg      <= sinit_next;
        qst_reg        <= qst_next;
        rstep_reg      <= rstep_next;
        ax_reg         <= ax_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        dcnt_reg       <= dcnt_next;
        di_reg         <= di_next;
        cnt_reg        <= cnt_next;
        t_reg          <= t_next;
        addr_reg       <= addr_next;
        inside_reg     <= inside_next;
        hit_reg        <= hit_next;
        status_reg     <= status_next;
        out_hit_reg    <= out_hit_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

endmodule

`default_nettype wire

// File: tb/tb_voxel_box_bitmap_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_voxel_box_bitmap_unit
// Drives set, query, re-box and unknown-code items through the input channel with
// random gaps, predicts every result from a behavioral copy of the bitmap,
// and compares each output item field by field against that prediction.
// ---------------------------------------------------------------------------
module tb_voxel_box_bitmap_unit;
    import vbb_pkg::*;

    localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint CMIN = -(64'sd1 <<< (CW - 1));

    typedef struct packed {
        logic              hit;
        logic [CNT_W-1:0]  count;
        logic [STAT_W-1:0] status;
    } voxel_result_t;

    logic clk;
    logic rst_n;
    vbb_in_if  in_ch ();
    vbb_out_if out_ch ();

    voxel_box_bitmap_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    bit            occupancy [0:VOXELS-1];
    bit            rebuilt   [0:VOXELS-1];
    longint        box_c1 [3];
    longint        box_c2 [3];
    int unsigned   marked;
    voxel_result_t pending_results [$];
    int            errors;
    bit            src_busy_mode;
    bit            snk_busy_mode;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    function automatic void box_geometry(input longint a [3], input longint b [3],
                                         output longint mn [3], output longint ed [3]);
        for (int k = 0; k < 3; k++)
        begin
            mn[k] = (a[k] < b[k]) ? a[k] : b[k];
            ed[k] = ((a[k] < b[k]) ? b[k] : a[k]) - mn[k] + 1;
        end
    endfunction

    function automatic longint voxel_addr(input longint ed [3], input longint x,
                                          input longint y, input longint z);
        return (y * ed[2] + z) * ed[0] + x;
    endfunction

    function automatic bit locate_voxel(input longint pt [3], output longint at);
        longint mn [3];
        longint ed [3];
        longint lc [3];
        box_geometry(box_c1, box_c2, mn, ed);
        at = 0;
        for (int k = 0; k < 3; k++)
        begin
            lc[k] = pt[k] - mn[k];
            if (lc[k] < 0 || lc[k] >= ed[k])
                return 1'b0;
        end
        at = voxel_addr(ed, lc[0], lc[1], lc[2]);
        return at < VOXELS;
    endfunction

    function automatic logic [STAT_W-1:0] rebox_bitmap(input logic [FUNC_W-1:0] f,
                                                       input longint a [3],
                                                       input longint b [3]);
        longint omn [3];
        longint oed [3];
        longint nmn [3];
        longint ned [3];
        longint sh [3];
        longint s [3];
        longint si;
        bit     ok;
        int unsigned cnt;
        box_geometry(box_c1, box_c2, omn, oed);
        box_geometry(a, b, nmn, ned);
        cnt = 0;
        for (int k = 0; k < 3; k++)
            if (ned[k] > MAX_EDGE)
                return ST_REFUSED;
        for (int k = 0; k < 3; k++)
            sh[k] = a[k] - box_c1[k];
        for (int i = 0; i < VOXELS; i++)
            rebuilt[i] = 1'b0;
        if (f != FN_EMPTY)
        begin
            for (longint ny = 0; ny < ned[1]; ny++)
                for (longint nz = 0; nz < ned[2]; nz++)
                    for (longint nx = 0; nx < ned[0]; nx++)
                    begin
                        longint n [3];
                        n[0] = nx;
                        n[1] = ny;
                        n[2] = nz;
                        ok = 1'b1;
                        for (int k = 0; k < 3; k++)
                        begin
                            if (f == FN_SHIFT)
                                s[k] = nmn[k] + n[k] - sh[k] - omn[k];
                            else
                                s[k] = (n[k] * oed[k]) / ned[k];
                            if (s[k] < 0 || s[k] >= oed[k])
                                ok = 1'b0;
                        end
                        if (ok)
                        begin
                            si = voxel_addr(oed, s[0], s[1], s[2]);
                            if (si < VOXELS && occupancy[si])
                            begin
                                rebuilt[voxel_addr(ned, nx, ny, nz)] = 1'b1;
                                cnt++;
                            end
                        end
                    end
        end
        occupancy = rebuilt;
        box_c1 = a;
        box_c2 = b;
        marked = cnt & 16'hFFFF;
        return ST_OK;
    endfunction

    function automatic voxel_result_t apply_voxel_op(input logic [FUNC_W-1:0] f,
                                                     input longint p [3],
                                                     input longint q [3],
                                                     input logic inc);
        voxel_result_t r;
        longint at;
        r = '0;
        r.status = ST_OK;
        case (f)
            FN_SET:
                if (locate_voxel(p, at))
                begin
                    if (occupancy[at] && !inc)
                        marked = (marked - 1) & 16'hFFFF;
                    else if (!occupancy[at] && inc)
                        marked = (marked + 1) & 16'hFFFF;
                    occupancy[at] = inc;
                end
                else
                    r.status = ST_OUTSIDE;
            FN_QUERY:
                if (locate_voxel(p, at))
                    r.hit = occupancy[at];
                else
                    r.status = ST_OUTSIDE;
            FN_EMPTY, FN_SHIFT, FN_RESAMPLE:
                r.status = rebox_bitmap(f, p, q);
            default: ;
        endcase
        r.count = marked[CNT_W-1:0];
        return r;
    endfunction

    task automatic send_item(input logic [FUNC_W-1:0] f, input coord_t x, input coord_t y,
                             input coord_t z, input coord_t ax, input coord_t ay,
                             input coord_t az, input logic inc);
        int gap;
        longint p [3];
        longint q [3];
        gap = src_busy_mode ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.func = f;
        in_ch.px = x;
        in_ch.py = y;
        in_ch.pz = z;
        in_ch.qx = ax;
        in_ch.qy = ay;
        in_ch.qz = az;
        in_ch.include_req = inc;
        in_ch.valid = 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        p[0] = x;
        p[1] = y;
        p[2] = z;
        q[0] = ax;
        q[1] = ay;
        q[2] = az;
        pending_results.push_back(apply_voxel_op(f, p, q, inc));
        @(negedge clk);
    endtask

    function automatic coord_t clamp_coord(input longint v);
        if (v > CMAX)
            return coord_t'(CMAX);
        if (v < CMIN)
            return coord_t'(CMIN);
        return coord_t'(v);
    endfunction

    function automatic coord_t near_axis(input int k);
        longint mn [3];
        longint ed [3];
        box_geometry(box_c1, box_c2, mn, ed);
        return clamp_coord(mn[k] - 1 + longint'($urandom_range(0, ed[k] + 1)));
    endfunction

    function automatic coord_t any_coord();
        return coord_t'($urandom);
    endfunction

    task automatic send_box(input logic [FUNC_W-1:0] f, input longint base [3],
                            input int ex, input int ey, input int ez);
        longint hi [3];
        hi[0] = base[0] + ex - 1;
        hi[1] = base[1] + ey - 1;
        hi[2] = base[2] + ez - 1;
        if ($urandom_range(0, 1))
            send_item(f, coord_t'(base[0]), coord_t'(base[1]), coord_t'(base[2]),
                      coord_t'(hi[0]), coord_t'(hi[1]), coord_t'(hi[2]), 1'($urandom));
        else
            send_item(f, coord_t'(hi[0]), coord_t'(hi[1]), coord_t'(hi[2]),
                      coord_t'(base[0]), coord_t'(base[1]), coord_t'(base[2]),
                      1'($urandom));
    endtask

    task automatic fill_box(input int n);
        repeat (n)
            send_item(FN_SET, near_axis(0), near_axis(1), near_axis(2), any_coord(),
                      any_coord(), any_coord(), $urandom_range(0, 3) != 0);
    endtask

    task automatic test_directed_points();
        longint b [3];
        send_item(FN_QUERY, 0, 0, 0, 0, 0, 0, 1'b0);
        send_item(FN_SET, 0, 0, 0, 0, 0, 0, 1'b1);
        send_item(FN_SET, 0, 0, 0, 0, 0, 0, 1'b1);
        send_item(FN_QUERY, 0, 0, 0, 0, 0, 0, 1'b0);
        send_item(FN_SET, coord_t'(CMAX), coord_t'(CMIN), 1, 0, 0, 0, 1'b1);
        send_item(FN_QUERY, coord_t'(CMIN), coord_t'(CMAX), -1, coord_t'(CMAX),
                  coord_t'(CMIN), coord_t'(CMAX), 1'b1);
        send_item(3'd5, 0, 0, 0, 0, 0, 0, 1'b1);
        send_item(3'd6, coord_t'(CMAX), coord_t'(CMAX), coord_t'(CMAX), 0, 0, 0, 1'b0);
        send_item(3'd7, coord_t'(CMIN), 0, 0, 0, 0, 0, 1'b1);
        b = '{CMAX - 3, CMIN, -2};
        send_box(FN_EMPTY, b, 4, 3, 5);
        fill_box(6);
        send_item(FN_SET, coord_t'(CMAX), coord_t'(CMIN), 2, 0, 0, 0, 1'b0);
        send_item(FN_QUERY, coord_t'(CMAX), coord_t'(CMIN + 2), 2, 0, 0, 0, 1'b0);
    endtask

    task automatic test_directed_boxes();
        longint b [3];
        b = '{-1, 2, 5};
        send_box(FN_EMPTY, b, 3, 4, 2);
        fill_box(8);
        send_box(FN_SHIFT, b, 3, 4, 2);
        send_box(FN_RESAMPLE, b, 3, 4, 2);
        b = '{0, 3, 4};
        send_box(FN_SHIFT, b, 4, 4, 3);
        send_box(FN_RESAMPLE, b, 7, 2, 5);
        send_box(FN_RESAMPLE, b, MAX_EDGE + 1, 2, 2);
        send_box(FN_SHIFT, b, 2, MAX_EDGE + 1, 2);
        send_box(FN_EMPTY, b, 2, 2, MAX_EDGE + 1);
        b = '{CMIN, CMIN, CMIN};
        send_box(FN_RESAMPLE, b, MAX_EDGE, MAX_EDGE, MAX_EDGE);
        fill_box(10);
        send_box(FN_RESAMPLE, b, 2, 3, 1);
        b = '{CMAX - 1, CMAX, CMAX - 2};
        send_box(FN_SHIFT, b, 2, 1, 3);
        send_item(FN_EMPTY, coord_t'(CMIN), 0, 0, coord_t'(CMAX), 0, 0, 1'b0);
    endtask

    task automatic test_random(input int n);
        longint b [3];
        longint mn [3];
        longint ed [3];
        int e [3];
        int sel;
        for (int i = 0; i < n; i++)
        begin
            if (i % 150 == 0)
            begin
                src_busy_mode = $urandom_range(0, 3) != 0;
                snk_busy_mode = $urandom_range(0, 3) != 0;
            end
            sel = $urandom_range(0, 99);
            if (sel < 12)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    e[k] = $urandom_range(0, 9) == 0 ? $urandom_range(1, 10)
                                                     : $urandom_range(1, 5);
                    if ($urandom_range(0, 49) == 0)
                        e[k] = MAX_EDGE + $urandom_range(1, 3);
                end
                box_geometry(box_c1, box_c2, mn, ed);
                case ($urandom_range(0, 3))
                    0: for (int k = 0; k < 3; k++)
                           b[k] = mn[k] + $signed($urandom_range(0, 6)) - 3;
                    1: for (int k = 0; k < 3; k++)
                           b[k] = $signed($urandom_range(0, 40)) - 20;
                    2: for (int k = 0; k < 3; k++)
                           b[k] = CMAX - MAX_EDGE - 3 + $urandom_range(0, MAX_EDGE + 3);
                    default: for (int k = 0; k < 3; k++)
                           b[k] = CMIN + $urandom_range(0, 40);
                endcase
                for (int k = 0; k < 3; k++)
                    if (b[k] + e[k] - 1 > CMAX)
                        b[k] = CMAX - e[k] + 1;
                send_box(FUNC_W'(FN_SHIFT + $urandom_range(0, 1)
                                 - ($urandom_range(0, 5) == 0)),
                         b, e[0], e[1], e[2]);
            end
            else if (sel < 55)
                fill_box(1);
            else if (sel < 90)
                send_item(FN_QUERY, near_axis(0), near_axis(1), near_axis(2), any_coord(),
                          any_coord(), any_coord(), 1'($urandom));
            else
                send_item(FUNC_W'($urandom_range(0, 7)), any_coord(), any_coord(),
                          any_coord(), any_coord(), any_coord(), any_coord(),
                          1'($urandom));
        end
    endtask

    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = snk_busy_mode ? $urandom_range(0, 16) : 0;
            if (stall > 0)
            begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        voxel_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result item with no prediction");
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.hit !== want.hit)
                    report_mismatch($sformatf("hit %b want %b", out_ch.hit, want.hit));
                if (out_ch.count !== want.count)
                    report_mismatch($sformatf("count %0d want %0d", out_ch.count,
                                              want.count));
                if (out_ch.status !== want.status)
                    report_mismatch($sformatf("status %0d want %0d", out_ch.status,
                                              want.status));
            end
        end
    end

    initial
    begin
        errors = 0;
        src_busy_mode = 1'b1;
        snk_busy_mode = 1'b1;
        for (int i = 0; i < VOXELS; i++)
            occupancy[i] = 1'b0;
        box_c1 = '{0, 0, 0};
        box_c2 = '{0, 0, 0};
        marked = 0;
        in_ch.valid = 1'b0;
        in_ch.func = FN_SET;
        in_ch.px = '0;
        in_ch.py = '0;
        in_ch.pz = '0;
        in_ch.qx = '0;
        in_ch.qy = '0;
        in_ch.qz = '0;
        in_ch.include_req = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed_points();
        test_directed_boxes();
        test_random(1820);
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// File: sim.f
design/vbb_pkg.sv
design/vbb_if.sv
design/vbb_ram.sv
design/voxel_box_bitmap_unit.sv
tb/tb_voxel_box_bitmap_unit.sv
